[rtl/mhsic_pkg.sv]
`default_nettype none

package mhsic_pkg;

    // fixed field widths
    localparam int RAW_W     = 24;
    localparam int OFFSET_W  = 32;
    localparam int ROW_W     = 63;
    localparam int FIELD_W   = 32;
    localparam int D_W       = RAW_W + 9;
    localparam int SUM_W     = 64;
    localparam int OUT_SHIFT = 22;
    localparam int ROOT_W    = 32;
    localparam int AXES      = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z    = 3'd5;

    // register reset values
    localparam logic [OFFSET_W-1:0] OFFSET_X_RST = 32'sd186244;
    localparam logic [OFFSET_W-1:0] OFFSET_Y_RST = -32'sd19458;
    localparam logic [OFFSET_W-1:0] OFFSET_Z_RST = 32'sd19384;

    // read status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ZERO = 1'b1;

    // saturation limits, sign extended to the sum width
    localparam logic signed [SUM_W-1:0] FIELD_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] FIELD_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } sample_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] field_from_row_z;
        logic signed [FIELD_W-1:0] field_from_row_x;
        logic signed [FIELD_W-1:0] field_from_row_y;
        logic [FIELD_W-1:0]        magnitude;
        logic                      read_status;
    } result_t;

    typedef logic [AXES-1:0][D_W-1:0]     diff_arr_t;
    typedef logic [AXES-1:0][SUM_W-1:0]   sum_arr_t;
    typedef logic [AXES-1:0][FIELD_W-1:0] field_arr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MERGE,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/mhsic_lane.sv]
`default_nettype none

module mhsic_lane #(
    parameter int COEF_WIDTH = 21
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire logic                                            start,
    input  wire mhsic_pkg::diff_arr_t                            d,
    input  wire logic [mhsic_pkg::ROW_W-1:0]                     row,
    output logic signed [mhsic_pkg::D_W+COEF_WIDTH+1:0]          acc,
    output logic                                                 done
);
    import mhsic_pkg::*;

    localparam int PROD_W = D_W + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 2;

    logic                     busy_reg;
    logic [1:0]               sel_reg;
    logic                     prod_vld_reg;
    logic                     last_reg;
    logic                     done_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [D_W-1:0]        d_sel;
    logic signed [COEF_WIDTH-1:0] c_sel;
    logic signed [PROD_W-1:0]     prod_next;

    // pick one column per cycle
    always_comb
    begin
        case (sel_reg)
            2'd0:
            begin
                d_sel = d[0];
                c_sel = row[0 +: COEF_WIDTH];
            end
            2'd1:
            begin
                d_sel = d[1];
                c_sel = row[COEF_WIDTH +: COEF_WIDTH];
            end
            2'd2:
            begin
                d_sel = d[2];
                c_sel = row[2*COEF_WIDTH +: COEF_WIDTH];
            end
            default:
            begin
                d_sel = '0;
                c_sel = '0;
            end
        endcase
        prod_next = d_sel * c_sel;
    end

    // product then accumulate, one column a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            sel_reg      <= 2'd0;
            prod_vld_reg <= 1'b0;
            last_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= busy_reg;
            last_reg     <= busy_reg && (sel_reg == 2'd2);
            done_reg     <= last_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                sel_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (sel_reg == 2'd2)
                    busy_reg <= 1'b0;
                else
                    sel_reg <= sel_reg + 2'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (busy_reg)
            prod_reg <= prod_next;
        if (start)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/mhsic_merge.sv]
`default_nettype none

module mhsic_merge (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire mhsic_pkg::sum_arr_t   sums,
    output mhsic_pkg::field_arr_t      fields,
    output logic [mhsic_pkg::SUM_W-1:0] sumsq,
    output logic                       done
);
    import mhsic_pkg::*;

    field_arr_t         field_reg;
    field_arr_t         field_next;
    logic               busy_reg;
    logic [1:0]         sel_reg;
    logic               sq_vld_reg;
    logic               last_reg;
    logic               done_reg;
    logic [SUM_W-1:0]   sq_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic signed [SUM_W-1:0] shifted;
    logic [FIELD_W-1:0]      f_sel;
    logic [FIELD_W-1:0]      f_abs;

    // floor shift to q.16 and saturate, all lanes at once
    always_comb
    begin
        shifted = '0;
        for (int k = 0; k < AXES; k++)
        begin
            shifted = signed'(sums[k]) >>> OUT_SHIFT;
            if (shifted > FIELD_MAX)
                field_next[k] = FIELD_MAX[FIELD_W-1:0];
            else if (shifted < FIELD_MIN)
                field_next[k] = FIELD_MIN[FIELD_W-1:0];
            else
                field_next[k] = shifted[FIELD_W-1:0];
        end
    end

    // one square per cycle through the shared multiplier
    always_comb
    begin
        case (sel_reg)
            2'd0:    f_sel = field_reg[0];
            2'd1:    f_sel = field_reg[1];
            2'd2:    f_sel = field_reg[2];
            default: f_sel = '0;
        endcase
        f_abs = f_sel[FIELD_W-1] ? (~f_sel + 1'b1) : f_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            sel_reg    <= 2'd0;
            sq_vld_reg <= 1'b0;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            sq_vld_reg <= busy_reg;
            last_reg   <= busy_reg && (sel_reg == 2'd2);
            done_reg   <= last_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                sel_reg  <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (sel_reg == 2'd2)
                    busy_reg <= 1'b0;
                else
                    sel_reg <= sel_reg + 2'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            field_reg <= field_next;
            sum_reg   <= '0;
        end
        else if (sq_vld_reg)
            sum_reg <= sum_reg + sq_reg;
        if (busy_reg)
            sq_reg <= SUM_W'(f_abs) * SUM_W'(f_abs);
    end

    assign fields = field_reg;
    assign sumsq  = sum_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

[rtl/mhsic_isqrt.sv]
`default_nettype none

module mhsic_isqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [mhsic_pkg::SUM_W-1:0]  radicand,
    output logic [mhsic_pkg::ROOT_W-1:0]      root,
    output logic                              done
);
    import mhsic_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    n_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [REM_W-1:0]    rem_shift;
    logic [REM_W-1:0]    trial;
    logic                fits;

    // one root bit per cycle, restoring method
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], n_reg[SUM_W-1 -: 2]};
        trial     = REM_W'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg    <= {n_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/magnetometer_hard_soft_iron_calibration_core.sv]
`default_nettype none

// Hard- and soft-iron magnetometer calibration. Each sample (three signed 24-bit counts)
// has the Q.8 hard-iron offsets removed, then goes through three row lanes that each
// form one row of the 3x3 Q.30 soft-iron product, one column per cycle. A merge stage
// shifts the row sums to Q.16 (floor), saturates them and sums their squares through one
// shared 32x32 multiplier, and a digit-by-digit square root produces the floor magnitude.
// A request passes in order through the offset register, the row lanes, the merge, the
// square root (a load and 32 bit steps) and the output register, where the result can be
// taken. A sample with all three axes zero skips the lanes, merge and square root and is
// loaded from the done state into the output register with read_status set and the last
// good outputs repeated. One sample is in work at a time; a finished result waits in the output
// register while the next sample is taken. Configuration writes are only allowed while
// no sample is in work; register writes beyond index 5 are ignored.
module magnetometer_hard_soft_iron_calibration_core #(
    parameter int COEF_WIDTH = 21
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                sample_valid,
    output logic                                     sample_ready,
    input  wire mhsic_pkg::sample_t                  sample_data,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output mhsic_pkg::result_t                       result_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mhsic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mhsic_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mhsic_pkg::*;

    localparam int ACC_W = D_W + COEF_WIDTH + 2;

    state_t              state_reg;
    state_t              state_next;
    logic                err_reg;
    logic                err_next;
    diff_arr_t           d_reg;
    logic [OFFSET_W-1:0] offset_x_reg;
    logic [OFFSET_W-1:0] offset_y_reg;
    logic [OFFSET_W-1:0] offset_z_reg;
    logic [ROW_W-1:0]    row_x_reg;
    logic [ROW_W-1:0]    row_y_reg;
    logic [ROW_W-1:0]    row_z_reg;
    field_arr_t          held_field_reg;
    logic [FIELD_W-1:0]  held_mag_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic                    accept;
    logic                    all_zero;
    logic                    lane_go;
    logic                    load;
    logic [AXES-1:0]         lane_done;
    logic [AXES-1:0][ROW_W-1:0] lane_row;
    logic signed [ACC_W-1:0] lane_acc [AXES];
    sum_arr_t                sums;
    field_arr_t              merge_fields;
    logic [SUM_W-1:0]        sumsq;
    logic                    merge_done;
    logic [ROOT_W-1:0]       root;
    logic                    root_done;

    // handshakes
    assign sample_ready = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign accept       = sample_valid && sample_ready;
    assign all_zero     = (sample_data.raw_x == '0) && (sample_data.raw_y == '0)
                          && (sample_data.raw_z == '0);
    assign lane_go      = accept && !all_zero;
    assign load         = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= OFFSET_X_RST;
            offset_y_reg <= OFFSET_Y_RST;
            offset_z_reg <= OFFSET_Z_RST;
            row_x_reg    <= '0;
            row_y_reg    <= '0;
            row_z_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OFFSET_X: offset_x_reg <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_Y: offset_y_reg <= cfg_data[OFFSET_W-1:0];
                CFG_OFFSET_Z: offset_z_reg <= cfg_data[OFFSET_W-1:0];
                CFG_ROW_X:    row_x_reg    <= cfg_data[ROW_W-1:0];
                CFG_ROW_Y:    row_y_reg    <= cfg_data[ROW_W-1:0];
                CFG_ROW_Z:    row_z_reg    <= cfg_data[ROW_W-1:0];
                default:      ;
            endcase
        end
    end

    // offset removal, q.8 difference per axis
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d_reg[0] <= {sample_data.raw_x[RAW_W-1], sample_data.raw_x, 8'h00}
                        - {offset_x_reg[OFFSET_W-1], offset_x_reg};
            d_reg[1] <= {sample_data.raw_y[RAW_W-1], sample_data.raw_y, 8'h00}
                        - {offset_y_reg[OFFSET_W-1], offset_y_reg};
            d_reg[2] <= {sample_data.raw_z[RAW_W-1], sample_data.raw_z, 8'h00}
                        - {offset_z_reg[OFFSET_W-1], offset_z_reg};
        end
    end

    // row lanes in output order: row z, row x, row y
    assign lane_row[0] = row_z_reg;
    assign lane_row[1] = row_x_reg;
    assign lane_row[2] = row_y_reg;

    for (genvar k = 0; k < AXES; k++)
    begin : g_lane
        mhsic_lane #(
            .COEF_WIDTH (COEF_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_go),
            .d     (d_reg),
            .row   (lane_row[k]),
            .acc   (lane_acc[k]),
            .done  (lane_done[k])
        );
        assign sums[k] = SUM_W'(lane_acc[k]);
    end

    mhsic_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lane_done[0]),
        .sums   (sums),
        .fields (merge_fields),
        .sumsq  (sumsq),
        .done   (merge_done)
    );

    mhsic_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (merge_done),
        .radicand (sumsq),
        .root     (root),
        .done     (root_done)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    err_next   = all_zero;
                    state_next = all_zero ? ST_DONE : ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (lane_done[0])
                    state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (merge_done)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // held outputs and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_field_reg   <= '0;
            held_mag_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (load && !err_reg)
            begin
                held_field_reg <= merge_fields;
                held_mag_reg   <= root;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (err_reg)
            begin
                result_reg.field_from_row_z <= held_field_reg[0];
                result_reg.field_from_row_x <= held_field_reg[1];
                result_reg.field_from_row_y <= held_field_reg[2];
                result_reg.magnitude        <= held_mag_reg;
                result_reg.read_status      <= STATUS_ZERO;
            end
            else
            begin
                result_reg.field_from_row_z <= merge_fields[0];
                result_reg.field_from_row_x <= merge_fields[1];
                result_reg.field_from_row_y <= merge_fields[2];
                result_reg.magnitude        <= root;
                result_reg.read_status      <= STATUS_OK;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // a shown result always matches the held state
    a_held_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.field_from_row_z == held_field_reg[0])
                      && (result_data.field_from_row_x == held_field_reg[1])
                      && (result_data.field_from_row_y == held_field_reg[2])
                      && (result_data.magnitude == held_mag_reg))
        else $error("result differs from held outputs");

    // a new result only comes out of the done state
    a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // the root finishes only while the sequencer waits for it
    a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> (state_reg == ST_ROOT))
        else $error("square root finished out of sequence");

endmodule

`default_nettype wire
